// ----- src/epoch_to_calendar_date_macros.svh -----
// ----------------------------------------------------------------------------
// Epoch to calendar date: assertion macros
// Short forms for the concurrent checks used across the block. Each expects
// aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication.
`define ETC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ETC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/etc_pkg.sv -----
// ----------------------------------------------------------------------------
// Epoch to calendar date: package
// Microcode word layout, step addresses, datapath status and calendar
// constants shared by the sequencer, microcode ROM and datapath.
// ----------------------------------------------------------------------------
package etc_pkg;

    typedef logic [3:0] step_t;

    // Microcode step addresses
    localparam step_t StepIdle      = 4'd0;
    localparam step_t StepDayDiv    = 4'd1;
    localparam step_t StepHourLoad  = 4'd2;
    localparam step_t StepHourDiv   = 4'd3;
    localparam step_t StepMinLoad   = 4'd4;
    localparam step_t StepMinDiv    = 4'd5;
    localparam step_t StepWeekLoad  = 4'd6;
    localparam step_t StepWeekDiv   = 4'd7;
    localparam step_t StepWeekSave  = 4'd8;
    localparam step_t StepYear      = 4'd9;
    localparam step_t StepMonth     = 4'd10;
    localparam step_t StepFinish    = 4'd11;
    localparam step_t StepLast      = StepFinish;

    typedef enum logic [3:0] {
        OP_LOAD_SEC,
        OP_DIV,
        OP_LOAD_HOUR,
        OP_LOAD_MIN,
        OP_LOAD_DOW,
        OP_SAVE_DOW,
        OP_YEAR,
        OP_MONTH,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN,
        DIV_WEEK
    } div_sel_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_IN,
        COND_YEAR_MORE,
        COND_MONTH_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t        op;
        div_sel_t   div_sel;
        cond_t      cond;
        step_t      target;
    } ctrl_word_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_busy;
    } dp_status_t;

    localparam logic [16:0] SecsPerDay  = 17'd86400;
    localparam logic [16:0] SecsPerHour = 17'd3600;
    localparam logic [16:0] SecsPerMin  = 17'd60;
    localparam logic [16:0] DaysPerWeek = 17'd7;

    // Rounded-up reciprocals of the odd parts of the divisors. Exact over each
    // dividend's range once the power-of-two factor is shifted off:
    // day 2^35/675, hour 2^21/225, minute 2^14/15, week 2^19/7.
    localparam logic [25:0] RecipDay  = 26'd50903317;
    localparam logic [13:0] RecipHour = 14'd9321;
    localparam logic [10:0] RecipMin  = 11'd1093;
    localparam logic [16:0] RecipWeek = 17'd74899;

    localparam logic [11:0] FirstYear = 12'd1970;
    // 1970 mod 4, mod 100, mod 400
    localparam logic [1:0]  FirstYearMod4   = 2'd2;
    localparam logic [6:0]  FirstYearMod100 = 7'd70;
    localparam logic [8:0]  FirstYearMod400 = 9'd370;
    // Julian day number of 1970-01-01 mod 7
    localparam logic [15:0] JdnOffsetMod7 = 16'd3;

    localparam logic [8:0] DaysCommonYear = 9'd365;
    localparam logic [8:0] DaysLeapYear   = 9'd366;
    localparam logic [3:0] MonthDec       = 4'd11;

    function automatic logic [16:0] divisor_of(input div_sel_t sel);
        logic [16:0] d;
        unique case (sel)
            DIV_DAY:  d = SecsPerDay;
            DIV_HOUR: d = SecsPerHour;
            DIV_MIN:  d = SecsPerMin;
            DIV_WEEK: d = DaysPerWeek;
            default:  d = SecsPerDay;
        endcase
        return d;
    endfunction

    // Month index 0 is January.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd1:                      d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ----- src/epoch_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// Epoch to calendar date: top level
// Microcode sequencer around the datapath: step counter and conditional
// jumps.
// ----------------------------------------------------------------------------
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian year, month, day, hour, minute, second and weekday (0 Monday to
// 6 Sunday), for the full range up to 2106-02-07 06:28:15. One item is worked
// at a time by a microcoded datapath: each of the four divisions by a constant
// (days, hours, minutes, weekday) is a reciprocal-multiply step followed by a
// step that forms the remainder; then the year loop subtracts one elapsed year
// per step and the month loop one elapsed month per step. The result register
// is loaded in the finish step once the output is free, and s_ready is high
// again the cycle after. The result register holds one finished item, so a new
// input transfer is taken while the previous result still waits for m_ready;
// the next item then holds in its last step until that result is taken.

`include "epoch_to_calendar_date_macros.svh"

module epoch_to_calendar_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [2:0]  m_day_of_week
);
    import etc_pkg::*;

    step_t      pc_reg, pc_next;
    ctrl_word_t cw;
    dp_status_t status;
    logic       take_jump;
    logic       finish_stall;

    etc_ucode_rom u_rom (
        .pc (pc_reg),
        .cw (cw)
    );

    etc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cw              (cw),
        .status          (status),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second),
        .m_day_of_week   (m_day_of_week)
    );

    assign s_ready = (pc_reg == StepIdle);

    always_comb begin
        unique case (cw.cond)
            COND_NONE:       take_jump = 1'b0;
            COND_ALWAYS:     take_jump = 1'b1;
            COND_NO_IN:      take_jump = !s_valid;
            COND_YEAR_MORE:  take_jump = !status.year_done;
            COND_MONTH_MORE: take_jump = !status.month_done;
            COND_OUT_BUSY:   take_jump = status.out_busy;
            default:         take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (take_jump) begin
            pc_next = cw.target;
        end else if (pc_reg == StepLast) begin
            pc_next = StepIdle;
        end else begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= StepIdle;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign finish_stall = (pc_reg == StepFinish) && status.out_busy;

    `ETC_ASSERT_NXT(a_accept_starts, s_valid && s_ready, pc_reg == StepDayDiv, "bad start")
    `ETC_ASSERT_NXT(a_finish_waits, finish_stall, pc_reg == StepFinish, "left finish early")
    `ETC_ASSERT_IMP(a_result_src, $rose(m_valid), $past(pc_reg) == StepFinish, "stray result")

endmodule

// ----- src/etc_ucode_rom.sv -----
// ----------------------------------------------------------------------------
// Epoch to calendar date: microcode ROM
// Control program: one control word per step address.
// ----------------------------------------------------------------------------
module etc_ucode_rom (
    input  etc_pkg::step_t      pc,
    output etc_pkg::ctrl_word_t cw
);
    import etc_pkg::*;

    // a load step forms the remainder of the division just before it
    always_comb begin
        unique case (pc)
            StepIdle:     cw = '{OP_LOAD_SEC,  DIV_DAY,  COND_NO_IN,      StepIdle};
            StepDayDiv:   cw = '{OP_DIV,       DIV_DAY,  COND_NONE,       StepIdle};
            StepHourLoad: cw = '{OP_LOAD_HOUR, DIV_DAY,  COND_NONE,       StepIdle};
            StepHourDiv:  cw = '{OP_DIV,       DIV_HOUR, COND_NONE,       StepIdle};
            StepMinLoad:  cw = '{OP_LOAD_MIN,  DIV_HOUR, COND_NONE,       StepIdle};
            StepMinDiv:   cw = '{OP_DIV,       DIV_MIN,  COND_NONE,       StepIdle};
            StepWeekLoad: cw = '{OP_LOAD_DOW,  DIV_MIN,  COND_NONE,       StepIdle};
            StepWeekDiv:  cw = '{OP_DIV,       DIV_WEEK, COND_NONE,       StepIdle};
            StepWeekSave: cw = '{OP_SAVE_DOW,  DIV_WEEK, COND_NONE,       StepIdle};
            StepYear:     cw = '{OP_YEAR,      DIV_DAY,  COND_YEAR_MORE,  StepYear};
            StepMonth:    cw = '{OP_MONTH,     DIV_DAY,  COND_MONTH_MORE, StepMonth};
            StepFinish:   cw = '{OP_FINISH,    DIV_DAY,  COND_OUT_BUSY,   StepFinish};
            // unused addresses return to idle
            default:      cw = '{OP_LOAD_SEC,  DIV_DAY,  COND_ALWAYS,     StepIdle};
        endcase
    end

endmodule

// ----- src/etc_datapath.sv -----
// ----------------------------------------------------------------------------
// Epoch to calendar date: datapath
// Shared reciprocal-multiply divider, year and month subtract units, result
// registers and the output channel.
// ----------------------------------------------------------------------------
`include "epoch_to_calendar_date_macros.svh"

module etc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  etc_pkg::ctrl_word_t cw,
    output etc_pkg::dp_status_t status,
    input  logic [31:0]         s_epoch_seconds,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [11:0]         m_year,
    output logic [3:0]          m_month,
    output logic [4:0]          m_day,
    output logic [4:0]          m_hour,
    output logic [5:0]          m_minute,
    output logic [5:0]          m_second,
    output logic [2:0]          m_day_of_week
);
    import etc_pkg::*;

    logic [31:0] num_reg,    num_next;
    logic [15:0] quo_reg,    quo_next;
    logic [15:0] days_reg,   days_next;
    logic [11:0] year_reg,   year_next;
    logic [1:0]  y4_reg,     y4_next;
    logic [6:0]  y100_reg,   y100_next;
    logic [8:0]  y400_reg,   y400_next;
    logic [3:0]  month_reg,  month_next;
    logic [4:0]  hour_reg,   hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [2:0]  dow_reg,    dow_next;

    logic        m_valid_reg, m_valid_next;
    logic [11:0] m_year_reg;
    logic [3:0]  m_month_reg;
    logic [4:0]  m_day_reg;
    logic [4:0]  m_hour_reg;
    logic [5:0]  m_minute_reg;
    logic [5:0]  m_second_reg;
    logic [2:0]  m_dow_reg;

    logic [16:0] divisor;
    logic [24:0] mul_a;
    logic [25:0] mul_b;
    logic [50:0] product;
    logic [15:0] quo_calc;
    logic [32:0] quo_prod;
    logic [16:0] rem;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [15:0] week_sum;
    logic        out_write;
    logic        rem_step;
    logic        result_in_range;

    assign divisor = divisor_of(cw.div_sel);

    // dividend with the divisor's power-of-two factor shifted off
    always_comb begin
        unique case (cw.div_sel)
            DIV_DAY: begin
                mul_a = num_reg[31:7];
                mul_b = RecipDay;
            end
            DIV_HOUR: begin
                mul_a = {12'd0, num_reg[16:4]};
                mul_b = {12'd0, RecipHour};
            end
            DIV_MIN: begin
                mul_a = {15'd0, num_reg[11:2]};
                mul_b = {15'd0, RecipMin};
            end
            DIV_WEEK: begin
                mul_a = {9'd0, num_reg[15:0]};
                mul_b = {9'd0, RecipWeek};
            end
            default: begin
                mul_a = num_reg[31:7];
                mul_b = RecipDay;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_comb begin
        unique case (cw.div_sel)
            DIV_DAY:  quo_calc = product[50:35];
            DIV_HOUR: quo_calc = {11'd0, product[25:21]};
            DIV_MIN:  quo_calc = {10'd0, product[19:14]};
            DIV_WEEK: quo_calc = {3'd0, product[31:19]};
            default:  quo_calc = product[50:35];
        endcase
    end

    // every remainder fits 17 bits, so the low bits of the difference suffice
    assign quo_prod = quo_reg * divisor;
    assign rem      = num_reg[16:0] - quo_prod[16:0];

    assign leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign ylen = leap ? DaysLeapYear : DaysCommonYear;
    assign mlen = month_days(month_reg, leap);

    // day count never exceeds 49710, so the offset sum stays in 16 bits
    assign week_sum = days_reg + JdnOffsetMod7;

    assign status.year_done  = (days_reg < {7'd0, ylen});
    assign status.month_done = (month_reg == MonthDec) || (days_reg < {11'd0, mlen});
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign out_write = (cw.op == OP_FINISH) && !status.out_busy;

    always_comb begin
        num_next    = num_reg;
        quo_next    = quo_reg;
        days_next   = days_reg;
        year_next   = year_reg;
        y4_next     = y4_reg;
        y100_next   = y100_reg;
        y400_next   = y400_reg;
        month_next  = month_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        dow_next    = dow_reg;
        unique case (cw.op)
            OP_LOAD_SEC: begin
                num_next = s_epoch_seconds;
            end
            OP_DIV: begin
                quo_next = quo_calc;
            end
            OP_LOAD_HOUR: begin
                days_next = quo_reg;
                year_next = FirstYear;
                y4_next   = FirstYearMod4;
                y100_next = FirstYearMod100;
                y400_next = FirstYearMod400;
                num_next  = {15'd0, rem};
            end
            OP_LOAD_MIN: begin
                hour_next = quo_reg[4:0];
                num_next  = {15'd0, rem};
            end
            OP_LOAD_DOW: begin
                minute_next = quo_reg[5:0];
                second_next = rem[5:0];
                num_next    = {16'd0, week_sum};
            end
            OP_SAVE_DOW: begin
                dow_next   = rem[2:0];
                month_next = 4'd0;
            end
            OP_YEAR: begin
                if (!status.year_done) begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 12'd1;
                    y4_next   = y4_reg + 2'd1;
                    y100_next = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
                    y400_next = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
                end
            end
            OP_MONTH: begin
                if (!status.month_done) begin
                    days_next  = days_reg - {11'd0, mlen};
                    month_next = month_reg + 4'd1;
                end
            end
            OP_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (out_write) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        y4_reg     <= y4_next;
        y100_reg   <= y100_next;
        y400_reg   <= y400_next;
        month_reg  <= month_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        dow_reg    <= dow_next;
        if (out_write) begin
            m_year_reg   <= year_reg;
            m_month_reg  <= month_reg + 4'd1;
            m_day_reg    <= days_reg[4:0] + 5'd1;
            m_hour_reg   <= hour_reg;
            m_minute_reg <= minute_reg;
            m_second_reg <= second_reg;
            m_dow_reg    <= dow_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_year        = m_year_reg;
    assign m_month       = m_month_reg;
    assign m_day         = m_day_reg;
    assign m_hour        = m_hour_reg;
    assign m_minute      = m_minute_reg;
    assign m_second      = m_second_reg;
    assign m_day_of_week = m_dow_reg;

    assign rem_step = (cw.op == OP_LOAD_HOUR) || (cw.op == OP_LOAD_MIN)
                      || (cw.op == OP_LOAD_DOW) || (cw.op == OP_SAVE_DOW);
    assign result_in_range = (m_month_reg != 4'd0) && (m_month_reg <= 4'd12)
                             && (m_hour_reg < 5'd24) && (m_dow_reg < 3'd7);

    `ETC_ASSERT_IMP(a_rem_in_range, rem_step, rem < divisor, "remainder out of range")
    `ETC_ASSERT_IMP(a_result_fields, m_valid_reg, result_in_range, "result field out of range")
    `ETC_ASSERT_NXT(a_finish_loads, out_write, m_valid_reg && m_year_reg == year_reg, "no result")

endmodule
